// File: src/sorted_unique_code_table_top_assert.svh
// assertion macros for the sorted code table
// used by sorted_unique_code_table_top, needs clk_i and rst_ni in scope
`ifndef SORTED_UNIQUE_CODE_TABLE_TOP_ASSERT_SVH
`define SORTED_UNIQUE_CODE_TABLE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define SUCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sorted code table check failed");
`define SUCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted code table implication failed");
`define SUCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted code table sequence failed");
`else
`define SUCT_ASSERT(lbl, prop)
`define SUCT_ASSERT_IMP(lbl, ante, cons)
`define SUCT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/suct_pkg.sv
// types and constants of the sorted code table
// no dependencies
`default_nettype none

package suct_pkg;

  localparam int unsigned CODE_W   = 16;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_OK        = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_ROW   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_DONE = 2'd2
  } fsm_e;

  // control from the head unit to the ring of cells
  typedef struct packed {
    logic              shift;
    logic [CODE_W-1:0] push;
  } ring_ctl_t;

endpackage

`default_nettype wire

// File: src/sorted_unique_code_table_top.sv
// top level of the sorted code table: ring of code cells and head unit
// depends on suct_pkg, suct_cell, suct_head and the assertion header
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   req_type_i, code_i, row_index_i
// out      output     out_valid_o / out_stall_i position_o, found_o, code_out_o,
//                                               entry_count_o, status_o
//
// in each transaction the whole ring rotates once
// past the compare tap at cell 0, then the result is loaded into the output register
// a new transaction is taken while an earlier result still waits in the output register
// reset clears the entry count and the control state, cell contents stay as they are
// a stalled output holds the finished transaction in the head unit until taken
`default_nettype none

`include "sorted_unique_code_table_top_assert.svh"

module sorted_unique_code_table_top
  import suct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [CODE_W-1:0]   code_i,
  input  wire logic [ROW_W-1:0]    row_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [POS_W-1:0]         position_o,
  output logic                     found_o,
  output logic [CODE_W-1:0]        code_out_o,
  output logic [POS_W-1:0]         entry_count_o,
  output logic [STATUS_W-1:0]      status_o
);

  ring_ctl_t         ring_ctl;
  logic [CODE_W-1:0] cell_q [TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_tail
      suct_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (ring_ctl.shift),
        .d_i     (ring_ctl.push),
        .q_o     (cell_q[i])
      );
    end else begin : g_body
      suct_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (ring_ctl.shift),
        .d_i     (cell_q[i+1]),
        .q_o     (cell_q[i])
      );
    end
  end

  suct_head #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_head (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .code_i        (code_i),
    .row_index_i   (row_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .position_o    (position_o),
    .found_o       (found_o),
    .code_out_o    (code_out_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o),
    .tap_i         (cell_q[0]),
    .ring_ctl_o    (ring_ctl)
  );

  `SUCT_ASSERT(a_found_matches_ok, out_valid_o |-> (found_o == (status_o == ST_OK)))
  `SUCT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `SUCT_ASSERT_IMP(a_shift_only_busy, ring_ctl.shift, in_stall_o)
  `SUCT_ASSERT_IMP(a_no_code_when_missing, out_valid_o && !found_o,
                   (code_out_o == '0) || (status_o == ST_INSERTED))

endmodule

`default_nettype wire

// File: src/suct_cell.sv
// one storage cell of the code ring
// depends on suct_pkg
`default_nettype none

module suct_cell
  import suct_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              shift_i,
  input  wire logic [CODE_W-1:0] d_i,
  output logic      [CODE_W-1:0] q_o
);

  logic [CODE_W-1:0] code_q;
  logic [CODE_W-1:0] code_d;

  always_comb begin
    code_d = shift_i ? d_i : code_q;
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign q_o = code_q;

endmodule

`default_nettype wire

// File: src/suct_head.sv
// head unit of the code ring: compare, insert splice, count and result register
// depends on suct_pkg
`default_nettype none

module suct_head
  import suct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [CODE_W-1:0]   code_i,
  input  wire logic [ROW_W-1:0]    row_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [POS_W-1:0]         position_o,
  output logic                     found_o,
  output logic [CODE_W-1:0]        code_out_o,
  output logic [POS_W-1:0]         entry_count_o,
  output logic [STATUS_W-1:0]      status_o,
  input  wire logic [CODE_W-1:0]   tap_i,
  output ring_ctl_t                ring_ctl_o
);

  localparam int unsigned KW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > ROW_W) ? CNT_W : ROW_W;
  localparam logic [KW-1:0]    K_LAST = KW'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  fsm_e              state_q, state_d;
  logic [KW-1:0]     k_q, k_d;
  logic [1:0]        req_q;
  logic [CODE_W-1:0] code_q;
  logic [ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]  held_q, held_d;
  logic              res_q, res_d;
  logic              present_q, present_d;
  logic              ins_q, ins_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CODE_W-1:0] carry_q, carry_d;
  logic [CODE_W-1:0] cap_q, cap_d;

  logic                out_valid_q, out_valid_d;
  logic [POS_W-1:0]    opos_q, opos_d;
  logic                ofound_q, ofound_d;
  logic [CODE_W-1:0]   ocode_q, ocode_d;
  logic [POS_W-1:0]    ocnt_q, ocnt_d;
  status_e             ostat_q, ostat_d;

  logic accept;
  logic entry_ok;
  logic lt;
  logic eq;
  logic row_hit;
  logic row_ok;
  logic is_lookup;
  logic full;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != FSM_IDLE);
  assign entry_ok  = CNT_W'(k_q) < held_q;
  assign lt        = entry_ok && (tap_i < code_q);
  assign eq        = entry_ok && (tap_i == code_q);
  assign row_hit   = CMP_W'(k_q) == CMP_W'(row_q);
  assign row_ok    = CMP_W'(row_q) < CMP_W'(held_q);
  assign is_lookup = (req_q == REQ_INSERT) || (req_q == REQ_FIND);
  assign full      = (held_q == FULL_CNT);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    held_d      = held_q;
    res_d       = res_q;
    present_d   = present_q;
    ins_d       = ins_q;
    pos_d       = pos_q;
    carry_d     = carry_q;
    cap_d       = cap_q;
    out_valid_d = out_valid_q && out_stall_i;
    opos_d      = opos_q;
    ofound_d    = ofound_q;
    ocode_d     = ocode_q;
    ocnt_d      = ocnt_q;
    ostat_d     = ostat_q;
    ring_ctl_o.shift = 1'b0;
    ring_ctl_o.push  = tap_i;

    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          state_d   = FSM_SCAN;
          k_d       = '0;
          res_d     = 1'b0;
          present_d = 1'b0;
          ins_d     = 1'b0;
          pos_d     = held_q;
          cap_d     = '0;
        end
      end
      FSM_SCAN: begin
        ring_ctl_o.shift = 1'b1;
        if (is_lookup) begin
          if (ins_q) begin
            ring_ctl_o.push = carry_q;
            carry_d         = tap_i;
          end else if (!res_q && !lt) begin
            res_d = 1'b1;
            pos_d = CNT_W'(k_q);
            if (eq) begin
              present_d = 1'b1;
            end else if ((req_q == REQ_INSERT) && !full) begin
              ring_ctl_o.push = code_q;
              carry_d         = tap_i;
              ins_d           = 1'b1;
            end
          end
        end else if ((req_q == REQ_READ) && row_hit) begin
          cap_d = tap_i;
        end
        if (k_q == K_LAST) begin
          state_d = FSM_DONE;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      FSM_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d     = FSM_IDLE;
          out_valid_d = 1'b1;
          held_d      = held_q + CNT_W'(ins_q);
          ocnt_d      = POS_W'(held_q + CNT_W'(ins_q));
          unique case (req_q)
            REQ_INSERT, REQ_FIND: begin
              opos_d   = POS_W'(pos_q);
              ofound_d = present_q;
              ocode_d  = (present_q || ins_q) ? code_q : '0;
              priority if (present_q) begin
                ostat_d = ST_OK;
              end else if (ins_q) begin
                ostat_d = ST_INSERTED;
              end else if (req_q == REQ_FIND) begin
                ostat_d = ST_NOT_FOUND;
              end else begin
                ostat_d = ST_FULL;
              end
            end
            REQ_READ: begin
              opos_d   = POS_W'(row_q);
              ofound_d = row_ok;
              ocode_d  = row_ok ? cap_q : '0;
              ostat_d  = row_ok ? ST_OK : ST_BAD_ROW;
            end
            default: begin
              opos_d   = '0;
              ofound_d = 1'b0;
              ocode_d  = '0;
              ostat_d  = ST_BAD_ROW;
            end
          endcase
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      res_q       <= 1'b0;
      present_q   <= 1'b0;
      ins_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      res_q       <= res_d;
      present_q   <= present_d;
      ins_q       <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      code_q <= code_i;
      row_q  <= row_index_i;
    end
    pos_q    <= pos_d;
    carry_q  <= carry_d;
    cap_q    <= cap_d;
    opos_q   <= opos_d;
    ofound_q <= ofound_d;
    ocode_q  <= ocode_d;
    ocnt_q   <= ocnt_d;
    ostat_q  <= ostat_d;
  end

  assign out_valid_o   = out_valid_q;
  assign position_o    = opos_q;
  assign found_o       = ofound_q;
  assign code_out_o    = ocode_q;
  assign entry_count_o = ocnt_q;
  assign status_o      = ostat_q;

endmodule

`default_nettype wire

// File: tb/code_table_checker.sv
`timescale 1ns / 1ps
// checker for the sorted code table: watches both channels, keeps its own copy
// of the table, and compares every result transaction field by field
// depends on suct_pkg
module code_table_checker
  import suct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [CODE_W-1:0]   code_i,
  input  wire logic [ROW_W-1:0]    row_index_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic                found_i,
  input  wire logic [CODE_W-1:0]   code_out_i,
  input  wire logic [POS_W-1:0]    entry_count_i,
  input  wire logic [STATUS_W-1:0] status_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  typedef struct {
    logic [POS_W-1:0]  position;
    logic              found;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  entry_count;
    status_e           status;
  } table_reply_t;

  logic [CODE_W-1:0] code_tab [TABLE_DEPTH];
  int unsigned       held = 0;
  int unsigned       fails = 0;
  int unsigned       outstanding = 0;
  table_reply_t      reply_q [$];
  table_reply_t      want;

  assign fail_count_o = fails;
  assign pending_o    = outstanding;

  function automatic table_reply_t apply_request(input logic [1:0] kind,
                                                 input logic [CODE_W-1:0] c,
                                                 input logic [ROW_W-1:0] row);
    table_reply_t r;
    int unsigned  slot;
    r.position = '0;
    r.found    = 1'b0;
    r.code     = '0;
    r.status   = ST_BAD_ROW;
    slot = 0;
    if (kind == REQ_INSERT || kind == REQ_FIND) begin
      while (slot < held && code_tab[slot] < c) slot++;
      r.position = slot[POS_W-1:0];
      if (slot < held && code_tab[slot] == c) begin
        r.found  = 1'b1;
        r.code   = c;
        r.status = ST_OK;
      end else if (kind == REQ_FIND) begin
        r.status = ST_NOT_FOUND;
      end else if (held >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int i = held; i > slot; i--) code_tab[i] = code_tab[i-1];
        code_tab[slot] = c;
        held++;
        r.code   = c;
        r.status = ST_INSERTED;
      end
    end else if (kind == REQ_READ) begin
      r.position = {1'b0, row};
      if (row < held) begin
        r.found  = 1'b1;
        r.code   = code_tab[row];
        r.status = ST_OK;
      end
    end
    r.entry_count = held[POS_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CODE_W-1:0] exp_val,
                             input logic [CODE_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      outstanding = 0;
      reply_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        reply_q.push_back(apply_request(req_type_i, code_i, row_index_i));
        outstanding++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          $error("result transaction with no request outstanding");
          fails++;
        end else begin
          want = reply_q.pop_front();
          outstanding--;
          check_field("position", CODE_W'(want.position), CODE_W'(position_i));
          check_field("found", CODE_W'(want.found), CODE_W'(found_i));
          check_field("code_out", want.code, code_out_i);
          check_field("entry_count", CODE_W'(want.entry_count), CODE_W'(entry_count_i));
          check_field("status", CODE_W'(want.status), CODE_W'(status_i));
        end
      end
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench top for the sorted code table: clock, reset, request stimulus and
// result-side stalls, verdict from the failure count of code_table_checker
// depends on suct_pkg, sorted_unique_code_table_top and code_table_checker
module tb;
  import suct_pkg::*;

  localparam int unsigned DEPTH        = 256;
  localparam logic [1:0]  REQ_UNDEF    = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          req_type_i = REQ_INSERT;
  logic [CODE_W-1:0]   code_i = '0;
  logic [ROW_W-1:0]    row_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [POS_W-1:0]    position_o;
  logic                found_o;
  logic [CODE_W-1:0]   code_out_o;
  logic [POS_W-1:0]    entry_count_o;
  logic [STATUS_W-1:0] status_o;

  int unsigned       fail_count;
  int unsigned       pending;
  logic              quiet = 1'b0;
  logic              hold_req = 1'b0;
  bit                is_held [logic [CODE_W-1:0]];
  logic [CODE_W-1:0] held_codes [$];
  int unsigned       sent_kind [4] = '{default: 0};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sorted_unique_code_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .code_i,
    .row_index_i,
    .out_valid_o,
    .out_stall_i,
    .position_o,
    .found_o,
    .code_out_o,
    .entry_count_o,
    .status_o
  );

  code_table_checker #(
    .TABLE_DEPTH(DEPTH)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i    (in_stall_o),
    .req_type_i,
    .code_i,
    .row_index_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .position_i    (position_o),
    .found_i       (found_o),
    .code_out_i    (code_out_o),
    .entry_count_i (entry_count_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_req(input logic [1:0] kind, input logic [CODE_W-1:0] c,
                          input logic [ROW_W-1:0] row);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    code_i      <= c;
    row_index_i <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_kind[kind]++;
    if (kind == REQ_INSERT && !is_held.exists(c) && held_codes.size() < DEPTH) begin
      is_held[c] = 1'b1;
      held_codes.push_back(c);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [CODE_W-1:0] pick_held();
    return held_codes[$urandom_range(0, held_codes.size() - 1)];
  endfunction

  task automatic random_item(input int unsigned insert_pct);
    int unsigned       dice;
    int unsigned       rest;
    logic [CODE_W-1:0] c;
    logic [ROW_W-1:0]  row;
    dice = $urandom_range(0, 99);
    rest = 100 - insert_pct;
    c    = CODE_W'($urandom_range(0, 16'hffff));
    row  = ROW_W'($urandom_range(0, 8'hff));
    if (dice < insert_pct) begin
      if (held_codes.size() > 0 && $urandom_range(0, 5) == 0) begin
        c = pick_held();
      end else if ($urandom_range(0, 9) == 0) begin
        c = CODE_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                         : 16'hffff - $urandom_range(0, 3));
      end
      send_req(REQ_INSERT, c, row);
    end else if (dice < insert_pct + rest * 45 / 100) begin
      if (held_codes.size() > 0 && $urandom_range(0, 1) == 0) c = pick_held();
      send_req(REQ_FIND, c, row);
    end else if (dice < insert_pct + rest * 90 / 100) begin
      if (held_codes.size() > 0 && $urandom_range(0, 9) < 7) begin
        row = ROW_W'($urandom_range(0, held_codes.size() - 1));
      end
      send_req(REQ_READ, c, row);
    end else begin
      send_req(REQ_UNDEF, c, row);
    end
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned n;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_req(REQ_READ, 16'h0000, 8'h00);
    send_req(REQ_FIND, 16'hffff, 8'hff);
    send_req(REQ_INSERT, 16'h8000, 8'h00);
    send_req(REQ_INSERT, 16'h0000, 8'hff);
    send_req(REQ_INSERT, 16'hffff, 8'h00);
    send_req(REQ_INSERT, 16'h8000, 8'h00);
    send_req(REQ_INSERT, 16'h4000, 8'h00);
    send_req(REQ_INSERT, 16'h7fff, 8'h00);
    send_req(REQ_FIND, 16'h0000, 8'h00);
    send_req(REQ_FIND, 16'hffff, 8'h00);
    send_req(REQ_FIND, 16'h0001, 8'h00);
    send_req(REQ_FIND, 16'hfffe, 8'h00);
    send_req(REQ_FIND, 16'h8001, 8'h00);
    send_req(REQ_READ, 16'hffff, 8'd0);
    send_req(REQ_READ, 16'h0000, 8'd4);
    send_req(REQ_READ, 16'h0000, 8'd5);
    send_req(REQ_READ, 16'h0000, 8'hff);
    send_req(REQ_UNDEF, 16'hffff, 8'hff);
    send_req(REQ_UNDEF, 16'h0000, 8'h00);
    send_req(REQ_INSERT, 16'hffff, 8'h00);
    send_req(REQ_INSERT, 16'h0000, 8'h00);

    // mostly inserts until the table is full
    n = 0;
    while (held_codes.size() < DEPTH) begin
      if (n == 40) hold_req = 1'b1;
      if (n == 150) wait_for_results();
      random_item(90);
      n++;
    end
    wait_for_results();

    // full table: refused inserts, finds, reads and undefined requests
    for (int i = 0; i < 70; i++) begin
      if (i == 30) quiet = 1'b1;
      random_item(40);
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("sent %0d inserts, %0d finds, %0d reads, %0d undefined requests",
             sent_kind[REQ_INSERT], sent_kind[REQ_FIND], sent_kind[REQ_READ],
             sent_kind[REQ_UNDEF]);
    $display("table filled to %0d of %0d rows, with a long output hold-off and a full drain",
             held_codes.size(), DEPTH);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
